// ===== rtl/core/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned OFF_W   = 11;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PCT_MAX = 100;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  release_offset;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] granted_offset;
    logic [PCT_W-1:0] free_percent;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/core/ffba_cell.sv =====
// One table cell: holds one block entry and passes it to its neighbour on a shift.
module ffba_cell import ffba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic [ENTRY_W-1:0] entry_i,
  output logic [ENTRY_W-1:0] entry_o
);

  logic [ENTRY_W-1:0] entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/core/first_fit_block_allocator_top.sv =====
// Top level of the first-fit block allocator: cell ring, head logic and sequencer.
//
// Requests enter on in_valid_i/in_ready_o carrying an req_t (func, size_bytes,
// release_offset); results leave on out_valid_o/out_ready_i as an rsp_t.
// The block table lives in a ring of NUM_BLOCKS cells that rotates by one entry
// per cycle while a request is scanned or written, so the entry at the head cell
// is inspected and rewritten in table order while the rest of the ring shifts past it.
// A free request takes one rotation, between its accept and its response. An
// allocate request takes two rotations, one to find the first free run and one
// to write it. One request is in flight at a time.
// The free percentage is built up during the final rotation from the written
// entries, without a divider.
// The result sits in an output register, so a new request can be accepted while
// the previous result still waits; a finished request whose result cannot yet
// be loaded waits in the response state until the receiver takes the old one.
// Reset clears every cell (all blocks free) and returns the sequencer to idle.
module first_fit_block_allocator_top import ffba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS  = 64,
  parameter int unsigned BLOCK_BYTES = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IW    = $clog2(NUM_BLOCKS);
  localparam int unsigned CW    = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned AW0   = $clog2(NUM_BLOCKS * BLOCK_BYTES + BLOCK_BYTES + 1);
  localparam int unsigned CMPW  = (AW0 > 17) ? AW0 : 17;
  localparam int unsigned RW    = IW + 1;
  localparam int unsigned PQ0   = PCT_MAX / NUM_BLOCKS;
  localparam int unsigned PR0   = PCT_MAX % NUM_BLOCKS;
  localparam int unsigned PRODW = IW + 13;

  localparam logic [IW-1:0]   LAST_POS = IW'(NUM_BLOCKS - 1);
  localparam logic [CMPW-1:0] BB       = CMPW'(BLOCK_BYTES);
  localparam logic [RW-1:0]   NB_R     = RW'(NUM_BLOCKS);
  localparam logic [RW-1:0]   PR0_R    = RW'(PR0);

  state_e state_q, state_d;

  logic [ENTRY_W-1:0] cell_q   [NUM_BLOCKS];
  logic [ENTRY_W-1:0] cell_d   [NUM_BLOCKS];
  logic               shift;
  logic [ENTRY_W-1:0] head_in, head_out;

  logic               op_q, op_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [OFF_W-1:0]   roff_q, roff_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      run_q, run_d;
  logic [CMPW-1:0]    rb_q, rb_d;
  logic [CMPW-1:0]    acc_q, acc_d;
  logic [CMPW-1:0]    wb_q, wb_d;
  logic               found_q, found_d;
  logic [IW-1:0]      start_q, start_d;
  logic [CW-1:0]      need_q, need_d;
  logic [ENTRY_W-1:0] rem_q, rem_d;
  logic               hit_done_q, hit_done_d;
  logic               ok_q, ok_d;
  logic [PCT_W-1:0]   pq_q, pq_d;
  logic [RW-1:0]      pr_q, pr_d;

  logic               out_valid_q, out_valid_d;
  rsp_t               out_rsp_q, out_rsp_d;

  logic [CMPW-1:0]    size_ext, roff_ext;
  logic [CW-1:0]      run_n;
  logic [CMPW-1:0]    rb_n;
  logic [IW:0]        start_n;
  logic               in_run, hit;
  logic [RW-1:0]      pr_sum;
  logic [PRODW-1:0]   prod;

  // Cell ring: each cell takes its right neighbour, the last takes the head result.
  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    if (g == NUM_BLOCKS - 1) begin : g_last
      assign cell_d[g] = head_out;
    end else begin : g_mid
      assign cell_d[g] = cell_q[g+1];
    end
    ffba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_d[g]),
      .entry_o (cell_q[g])
    );
  end

  assign head_in  = cell_q[0];
  assign size_ext = CMPW'(size_q);
  assign roff_ext = CMPW'(roff_q);
  assign prod     = PRODW'(start_q) * PRODW'(BLOCK_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    size_q     <= size_d;
    roff_q     <= roff_d;
    pos_q      <= pos_d;
    run_q      <= run_d;
    rb_q       <= rb_d;
    acc_q      <= acc_d;
    wb_q       <= wb_d;
    found_q    <= found_d;
    start_q    <= start_d;
    need_q     <= need_d;
    rem_q      <= rem_d;
    hit_done_q <= hit_done_d;
    ok_q       <= ok_d;
    pq_q       <= pq_d;
    pr_q       <= pr_d;
    out_rsp_q  <= out_rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    size_d      = size_q;
    roff_d      = roff_q;
    pos_d       = pos_q;
    run_d       = run_q;
    rb_d        = rb_q;
    acc_d       = acc_q;
    wb_d        = wb_q;
    found_d     = found_q;
    start_d     = start_q;
    need_d      = need_q;
    rem_d       = rem_q;
    hit_done_d  = hit_done_q;
    ok_d        = ok_q;
    pq_d        = pq_q;
    pr_d        = pr_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    shift       = 1'b0;
    head_out    = head_in;
    run_n       = run_q + CW'(1);
    rb_n        = rb_q + BB;
    start_n     = (IW+1)'(pos_q) + (IW+1)'(1) - (IW+1)'(run_n);
    in_run      = 1'b0;
    hit         = 1'b0;
    pr_sum      = pr_q + PR0_R;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = in_req_i.func;
          size_d     = in_req_i.size_bytes;
          roff_d     = in_req_i.release_offset;
          pos_d      = '0;
          run_d      = '0;
          rb_d       = '0;
          acc_d      = '0;
          wb_d       = '0;
          found_d    = 1'b0;
          rem_d      = '0;
          hit_done_d = 1'b0;
          ok_d       = 1'b0;
          pq_d       = '0;
          pr_d       = '0;
          state_d    = (in_req_i.func == OP_ALLOC) ? ST_SCAN : ST_WRITE;
        end
      end

      // First rotation of an allocation: look for the lowest free run that holds the requested size.
      ST_SCAN: begin
        shift = 1'b1;
        if (head_in == '0) begin
          run_d = run_n;
          rb_d  = rb_n;
          if (!found_q && size_q != '0 && rb_n >= size_ext) begin
            found_d = 1'b1;
            start_d = start_n[IW-1:0];
            need_d  = run_n;
          end
        end else begin
          run_d = '0;
          rb_d  = '0;
        end
        pos_d = pos_q + IW'(1);
        if (pos_q == LAST_POS) begin
          pos_d   = '0;
          ok_d    = found_d;
          state_d = ST_WRITE;
        end
      end

      // Final rotation: mark or clear entries and count free blocks.
      ST_WRITE: begin
        shift = 1'b1;
        if (op_q == OP_ALLOC) begin
          in_run = found_q && (pos_q >= start_q) && (wb_q < size_ext);
          if (in_run) begin
            head_out = (pos_q == start_q) ? ENTRY_W'(need_q) : ENTRY_W'(1);
            wb_d     = wb_q + BB;
          end
        end else begin
          hit = !hit_done_q && (roff_ext >= acc_q) && (roff_ext < acc_q + BB);
          if (hit) begin
            hit_done_d = 1'b1;
            if (head_in != '0) begin
              ok_d     = 1'b1;
              head_out = '0;
              rem_d    = head_in - ENTRY_W'(1);
            end
          end else if (rem_q != '0) begin
            head_out = '0;
            rem_d    = rem_q - ENTRY_W'(1);
          end
        end
        acc_d = acc_q + BB;
        if (head_out == '0) begin
          if (pr_sum >= NB_R) begin
            pr_d = pr_sum - NB_R;
            pq_d = pq_q + PCT_W'(PQ0 + 1);
          end else begin
            pr_d = pr_sum;
            pq_d = pq_q + PCT_W'(PQ0);
          end
        end
        pos_d = pos_q + IW'(1);
        if (pos_q == LAST_POS) begin
          pos_d   = '0;
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_rsp_d.ok               = ok_q;
          out_rsp_d.granted_offset   = (ok_q && op_q == OP_ALLOC) ? prod[OFF_W-1:0] : '0;
          out_rsp_d.free_percent     = pq_q;
          state_d                    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  // Requests are only taken while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("request accepted outside idle");

  // A failed request never reports a granted offset (free requests are not checked here).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (!out_rsp_o.ok)) |-> out_rsp_o.granted_offset == '0)
    else $error("offset reported on failure");

  // The free percentage never exceeds one hundred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.free_percent <= PCT_W'(PCT_MAX))
    else $error("free percentage out of range");

  // The write rotation follows a completed scan, starting again at entry zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && pos_q == LAST_POS) |=> state_q == ST_WRITE && pos_q == '0)
    else $error("scan did not hand over to write rotation");
`endif

endmodule
